[rtl/ddo_pkg.sv]
// Shared types, constants and helper functions of the differential drive odometry block.
package ddo_pkg;

  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [19:0] SEP_RST = 20'd22282;
  localparam logic [16:0] RAD_RST = 17'd4915;
  localparam logic [23:0] TMO_RST = 24'd600000;
  localparam logic [1:0]  EN_RST  = 2'd3;

  typedef enum logic [1:0] {
    REG_SEP = 2'd0,
    REG_RAD = 2'd1,
    REG_TMO = 2'd2,
    REG_EN  = 2'd3
  } reg_idx_t;

  // Reciprocal of 15625 scaled by 2^52 and rounded up; exact for 38-bit dividends.
  localparam logic [38:0] DR_RECIP = 39'd288230376152;
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [29:0] BAM_SCALE = 30'd683565276;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  typedef struct packed {
    logic load;
    logic prep;
    logic setp;
    logic sums;
    logic sta;
    logic mdt0;
    logic mdt1;
    logic stb;
    logic muls;
    logic commit;
  } ddo_cmd_t;

  typedef struct packed {
    logic is_cmd;
    logic div_busy;
    logic cordic_busy;
  } ddo_stat_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0: a = 32'h20000000;
      5'd1: a = 32'h12E4051E;
      5'd2: a = 32'h09FB385B;
      5'd3: a = 32'h051111D4;
      5'd4: a = 32'h028B0D43;
      5'd5: a = 32'h0145D7E1;
      5'd6: a = 32'h00A2F61E;
      5'd7: a = 32'h00517C55;
      5'd8: a = 32'h0028BE53;
      5'd9: a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  function automatic logic [31:0] sat32(input logic neg, input logic [47:0] mag);
    logic [47:0] nm;
    logic [31:0] r;
    nm = -mag;
    if (!neg) begin
      r = (mag > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end else begin
      r = (mag > 48'h8000_0000) ? 32'h8000_0000 : nm[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/ddo_div.sv]
// Iterative restoring divider, one quotient bit per cycle.
module ddo_div #(
  parameter int WD = 20,
  parameter int WQ = 41
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [WD-1:0] num_hi,
  input  logic [WQ-1:0] num_lo,
  input  logic [WD-1:0] den,
  output logic          busy,
  output logic [WQ-1:0] quo
);
  localparam int CW = $clog2(WQ + 1);

  logic [WD-1:0] rem;
  logic [CW-1:0] cnt;
  logic [WD:0]   trial;
  logic [WD:0]   sub;
  logic          ge;

  always_comb begin
    trial = {rem, quo[WQ-1]};
    sub = trial - {1'b0, den};
    ge = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CW'(WQ);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num_hi;
      quo <= num_lo;
    end else if (busy) begin
      rem <= ge ? sub[WD-1:0] : trial[WD-1:0];
      quo <= {quo[WQ-2:0], ge};
    end
  end

endmodule

[rtl/ddo_cordic.sv]
// Iterative rotation CORDIC giving cosine and sine of a binary angle in Q4.30.
module ddo_cordic import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               busy,
  output logic signed [33:0] cos_v,
  output logic signed [33:0] sin_v
);
  localparam int NSTEP = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  logic signed [33:0] x, y, z;
  logic signed [33:0] za, zr;
  logic signed [33:0] xs, ys, at;
  logic               neg, neg_c;
  logic [4:0]         i;

  always_comb begin
    za = {{2{angle[31]}}, angle};
    zr = za;
    neg_c = 1'b0;
    if (za > 34'sd1073741824) begin
      zr = za - 34'sd2147483648;
      neg_c = 1'b1;
    end else if (za < -34'sd1073741824) begin
      zr = za + 34'sd2147483648;
      neg_c = 1'b1;
    end
    xs = x >>> i;
    ys = y >>> i;
    at = $signed({2'b00, atan_bam(i)});
    cos_v = neg ? -x : x;
    sin_v = neg ? -y : y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      i <= '0;
    end else if (start) begin
      busy <= 1'b1;
      i <= '0;
    end else if (busy) begin
      i <= i + 5'd1;
      if (i == 5'(NSTEP - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= CORDIC_GAIN;
      y <= '0;
      z <= zr;
      neg <= neg_c;
    end else if (busy) begin
      if (!z[33]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule

[rtl/ddo_datapath.sv]
// Datapath: configuration, odometry state, multipliers, dividers and result registers.
module ddo_datapath import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  ddo_cmd_t           cmd,
  output ddo_stat_t          stat,
  input  logic               action,
  input  logic signed [23:0] left_wheel_rate,
  input  logic signed [23:0] right_wheel_rate,
  input  logic [19:0]        step_time_us,
  input  logic signed [23:0] cmd_linear,
  input  logic signed [23:0] cmd_angular,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic signed [31:0] linear_velocity,
  output logic signed [31:0] angular_velocity,
  output logic signed [31:0] left_drive_rate,
  output logic signed [31:0] right_drive_rate,
  output logic               timed_out
);
  localparam int DRV_WD = 17;
  localparam int DRV_WQ = 48;
  localparam int ANG_WD = 20;
  localparam int ANG_WQ = 41;
  localparam int DR_WQ = 25;
  localparam int DA_WD = 40;
  localparam int DA_WQ = 42;

  logic [19:0] sep;
  logic [16:0] rad;
  logic [23:0] tmo;
  logic [1:0]  en;
  logic [19:0] sep_eff;
  logic [16:0] rad_eff;

  logic               act_r;
  logic signed [23:0] lrate_r, rrate_r, lin_r, ang_r;
  logic [19:0]        dt_r;

  logic [31:0] px, py, hdg, spl, spr, since;

  logic signed [41:0] ql_r, qr_r;
  logic signed [44:0] half_p;
  logic [39:0]        den_da;
  logic               s_neg, d_neg, l_neg, r_neg;
  logic [40:0]        s_mag, d_mag;
  logic [40:0]        p_s_lo, p_d_lo;
  logic [60:0]        p_s, p_d;
  logic signed [59:0] xp_r, yp_r;
  logic [53:0]        hlo_r;
  logic [23:0]        hhi_r;

  logic signed [41:0] sum_c, diff_c, sum_abs, diff_abs;
  logic signed [44:0] half_sh;
  logic signed [31:0] lin32, half32;
  logic [39:0]        ph_s, ph_d;
  logic [31:0]        spl_abs, spr_abs;
  logic signed [25:0] dr_s;
  logic [47:0]        da48;
  logic [53:0]        hlo_c, hhi_c;
  logic [47:0]        hsum;
  logic signed [59:0] xp_sh, yp_sh;
  logic [32:0]        acc;
  logic [31:0]        since_n;
  logic               tmo_hit;
  logic [31:0]        px_n, py_n, hdg_n;
  logic [23:0]        lin_mag;
  logic [31:0]        lin_ext;

  logic [38:0] pp_ac, pp_bc;
  logic [37:0] pp_ad, pp_bd;
  logic [39:0] dr_mid;
  logic [76:0] dr_prod;
  logic        dr_pend;

  logic              bl, br, bw, bda, cbusy;
  logic [DRV_WQ-1:0] q_l, q_r;
  logic [ANG_WQ-1:0] q_w;
  logic [DR_WQ-1:0]  q_dr;
  logic [DA_WQ-1:0]  q_da;
  logic signed [33:0] cos_v, sin_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep <= SEP_RST;
      rad <= RAD_RST;
      tmo <= TMO_RST;
      en <= EN_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_SEP: sep <= cfg_data[19:0];
        REG_RAD: rad <= cfg_data[16:0];
        REG_TMO: tmo <= cfg_data;
        REG_EN:  en <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sep_eff = (sep == 20'd0) ? 20'd1 : sep;
    rad_eff = (rad == 17'd0) ? 17'd1 : rad;
    sum_c = ql_r + qr_r;
    diff_c = qr_r - ql_r;
    sum_abs = sum_c[41] ? -sum_c : sum_c;
    diff_abs = diff_c[41] ? -diff_c : diff_c;
    half_sh = half_p >>> 17;
    half32 = half_sh[31:0];
    lin32 = {{8{lin_r[23]}}, lin_r};
    ph_s = s_mag[40:21] * dt_r;
    ph_d = d_mag[40:21] * dt_r;
    spl_abs = spl[31] ? -spl : spl;
    spr_abs = spr[31] ? -spr : spr;
    dr_s = s_neg ? -$signed({1'b0, q_dr}) : $signed({1'b0, q_dr});
    da48 = d_neg ? -{6'd0, q_da} : {6'd0, q_da};
    hlo_c = da48[23:0] * BAM_SCALE;
    hhi_c = da48[47:24] * BAM_SCALE;
    hsum = hlo_r[47:0] + {hhi_r, 24'd0};
    xp_sh = xp_r >>> 30;
    yp_sh = yp_r >>> 30;
    acc = {1'b0, since} + {13'd0, dt_r};
    since_n = acc[32] ? 32'hFFFF_FFFF : acc[31:0];
    tmo_hit = (since_n > {8'd0, tmo});
    px_n = px + xp_sh[31:0];
    py_n = py + yp_sh[31:0];
    hdg_n = hdg + hsum[47:16];
    lin_mag = s_mag[40:17];
    lin_ext = {8'd0, lin_mag};
    dr_mid = {2'd0, pp_ad} + {1'b0, pp_bc};
    dr_prod = {pp_ac, 38'd0} + {18'd0, dr_mid, 19'd0} + {39'd0, pp_bd};
    stat.is_cmd = act_r;
    stat.div_busy = bl | br | bw | dr_pend | bda;
    stat.cordic_busy = cbusy;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      lrate_r <= left_wheel_rate;
      rrate_r <= right_wheel_rate;
      dt_r <= step_time_us;
      lin_r <= cmd_linear;
      ang_r <= cmd_angular;
    end
    if (cmd.prep) begin
      ql_r <= en[0] ? $signed(lrate_r) * $signed({1'b0, rad}) : 42'sd0;
      qr_r <= en[1] ? $signed(rrate_r) * $signed({1'b0, rad}) : 42'sd0;
      half_p <= $signed(ang_r) * $signed({1'b0, sep});
      den_da <= sep_eff * US_PER_S;
    end
    if (cmd.sums) begin
      s_neg <= sum_c[41];
      d_neg <= diff_c[41];
      s_mag <= sum_abs[40:0];
      d_mag <= diff_abs[40:0];
    end
    if (cmd.sta) begin
      l_neg <= spl[31];
      r_neg <= spr[31];
    end
    if (cmd.mdt0) begin
      p_s_lo <= s_mag[20:0] * dt_r;
      p_d_lo <= d_mag[20:0] * dt_r;
    end
    if (cmd.mdt1) begin
      p_s <= {20'd0, p_s_lo} + {ph_s, 21'd0};
      p_d <= {20'd0, p_d_lo} + {ph_d, 21'd0};
    end
    // The distance divides by 2^23 * 15625: a shift, then a reciprocal product in two steps.
    if (cmd.stb) begin
      pp_ac <= p_s[60:42] * DR_RECIP[38:19];
      pp_ad <= p_s[60:42] * DR_RECIP[18:0];
      pp_bc <= p_s[41:23] * DR_RECIP[38:19];
      pp_bd <= p_s[41:23] * DR_RECIP[18:0];
    end
    if (dr_pend) begin
      q_dr <= dr_prod[76:52];
    end
    if (cmd.muls) begin
      xp_r <= dr_s * cos_v;
      yp_r <= dr_s * sin_v;
      hlo_r <= hlo_c;
      hhi_r <= hhi_c[23:0];
    end
    if (cmd.commit) begin
      if (act_r) begin
        pos_x <= px;
        pos_y <= py;
        heading <= hdg;
        linear_velocity <= '0;
        angular_velocity <= '0;
        timed_out <= 1'b0;
      end else begin
        pos_x <= px_n;
        pos_y <= py_n;
        heading <= hdg_n;
        if (dt_r == 20'd0) begin
          linear_velocity <= '0;
          angular_velocity <= '0;
        end else begin
          linear_velocity <= s_neg ? -lin_ext : lin_ext;
          angular_velocity <= sat32(d_neg, {7'd0, q_w});
        end
        timed_out <= tmo_hit;
      end
      left_drive_rate <= en[0] ? sat32(l_neg, q_l) : '0;
      right_drive_rate <= en[1] ? sat32(r_neg, q_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dr_pend <= 1'b0;
    end else begin
      dr_pend <= cmd.stb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      hdg <= '0;
      spl <= '0;
      spr <= '0;
      since <= '0;
    end else if (cmd.setp) begin
      spl <= lin32 - half32;
      spr <= lin32 + half32;
      since <= '0;
    end else if (cmd.commit && !act_r) begin
      px <= px_n;
      py <= py_n;
      hdg <= hdg_n;
      since <= since_n;
      if (tmo_hit) begin
        spl <= '0;
        spr <= '0;
      end
    end
  end

  ddo_div #(.WD(DRV_WD), .WQ(DRV_WQ)) u_div_l (
    .clk(clk), .rst(rst), .start(cmd.sta), .num_hi('0), .num_lo({spl_abs, 16'd0}),
    .den(rad_eff), .busy(bl), .quo(q_l)
  );

  ddo_div #(.WD(DRV_WD), .WQ(DRV_WQ)) u_div_r (
    .clk(clk), .rst(rst), .start(cmd.sta), .num_hi('0), .num_lo({spr_abs, 16'd0}),
    .den(rad_eff), .busy(br), .quo(q_r)
  );

  ddo_div #(.WD(ANG_WD), .WQ(ANG_WQ)) u_div_w (
    .clk(clk), .rst(rst), .start(cmd.sta), .num_hi('0), .num_lo(d_mag),
    .den(sep_eff), .busy(bw), .quo(q_w)
  );

  ddo_div #(.WD(DA_WD), .WQ(DA_WQ)) u_div_da (
    .clk(clk), .rst(rst), .start(cmd.stb), .num_hi({21'd0, p_d[60:42]}),
    .num_lo(p_d[41:0]), .den(den_da), .busy(bda), .quo(q_da)
  );

  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cmd.prep & ~act_r), .angle(hdg),
    .busy(cbusy), .cos_v(cos_v), .sin_v(sin_v)
  );

endmodule

[rtl/ddo_ctrl.sv]
// Controller state machine sequencing the odometry datapath and the output handshake.
module ddo_ctrl import ddo_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output ddo_cmd_t  cmd,
  input  ddo_stat_t stat
);
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_PREP = 11'b00000000010,
    S_SETP = 11'b00000000100,
    S_STA  = 11'b00000001000,
    S_SUMS = 11'b00000010000,
    S_MDT0 = 11'b00000100000,
    S_MDT1 = 11'b00001000000,
    S_STB  = 11'b00010000000,
    S_DIVW = 11'b00100000000,
    S_MULS = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_next = stat.is_cmd ? S_SETP : S_SUMS;
      end
      S_SETP: begin
        cmd.setp = 1'b1;
        state_next = S_STA;
      end
      S_STA: begin
        cmd.sta = 1'b1;
        state_next = S_DIVW;
      end
      S_SUMS: begin
        cmd.sums = 1'b1;
        state_next = S_MDT0;
      end
      S_MDT0: begin
        cmd.mdt0 = 1'b1;
        cmd.sta = 1'b1;
        state_next = S_MDT1;
      end
      S_MDT1: begin
        cmd.mdt1 = 1'b1;
        state_next = S_STB;
      end
      S_STB: begin
        cmd.stb = 1'b1;
        state_next = S_DIVW;
      end
      S_DIVW: begin
        if (!stat.div_busy && !stat.cordic_busy) begin
          state_next = stat.is_cmd ? S_DONE : S_MULS;
        end
      end
      S_MULS: begin
        cmd.muls = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/diff_drive_odometry.sv]
// Top level of the differential drive odometry block.
// A tick result and a command result are both set by the 48-step drive-rate dividers;
// the turn divider and CORDIC finish earlier. One beat is worked on at a time, and a
// beat can be held in its last state while an earlier result stalls; the next is
// accepted while a result waits.
// Synchronous reset clears pose, setpoints and timer and loads register defaults.
module diff_drive_odometry import ddo_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [23:0] left_wheel_rate,
  input  logic signed [23:0] right_wheel_rate,
  input  logic [19:0]        step_time_us,
  input  logic signed [23:0] cmd_linear,
  input  logic signed [23:0] cmd_angular,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic [31:0]        heading,
  output logic signed [31:0] linear_velocity,
  output logic signed [31:0] angular_velocity,
  output logic signed [31:0] left_drive_rate,
  output logic signed [31:0] right_drive_rate,
  output logic               timed_out
);
  ddo_cmd_t  cmd;
  ddo_stat_t stat;

  ddo_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .stat(stat)
  );

  ddo_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .stat(stat), .action(action), .left_wheel_rate(left_wheel_rate),
    .right_wheel_rate(right_wheel_rate), .step_time_us(step_time_us),
    .cmd_linear(cmd_linear), .cmd_angular(cmd_angular), .pos_x(pos_x), .pos_y(pos_y),
    .heading(heading), .linear_velocity(linear_velocity),
    .angular_velocity(angular_velocity), .left_drive_rate(left_drive_rate),
    .right_drive_rate(right_drive_rate), .timed_out(timed_out)
  );

endmodule

[test/testbench.sv]
// Self-checking testbench for the differential drive odometry block.
`timescale 1ns / 100ps

module testbench;
  import ddo_pkg::*;

  typedef struct {
    bit                 act;
    logic signed [23:0] lwr;
    logic signed [23:0] rwr;
    logic [19:0]        dt;
    logic signed [23:0] lin;
    logic signed [23:0] ang;
    bit                 zero_known;
  } beat_t;

  typedef struct {
    logic [31:0] px, py, hd, lv, av, ld, rd;
    logic        to;
  } pose_t;

  localparam longint MASK32 = 64'hFFFF_FFFF;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_SEP;
  logic [23:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic action = 0;
  logic signed [23:0] left_wheel_rate = 0, right_wheel_rate = 0, cmd_linear = 0, cmd_angular = 0;
  logic [19:0] step_time_us = 0;
  logic in_stall, out_valid, timed_out;
  logic signed [31:0] pos_x, pos_y, linear_velocity, angular_velocity;
  logic signed [31:0] left_drive_rate, right_drive_rate;
  logic [31:0] heading;

  diff_drive_odometry dut (.*);

  always #5 clk = ~clk;

  // Own copy of registers and pose state.
  longint sep_r, rad_r, tmo_r, en_r;
  longint px_s, py_s, hd_s, lsp_s, rsp_s, since_s;
  pose_t pose_expect_q[$];
  int errors = 0, n_ticks = 0, n_cmds = 0, n_timeouts = 0;
  int send_gap_pct = 0, recv_stall_pct = 0, idle_cycles = 0;

  longint unsigned atan_tab[32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  function automatic longint s32(longint v);
    return longint'(signed'(v[31:0]));
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) v = -64'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic void heading_sin_cos(longint a, output longint c, output longint s);
    longint z, x, y, t;
    bit neg;
    int n;
    z = a;
    x = 652032874;
    y = 0;
    neg = 0;
    n = (dut.CORDIC_STEPS > 32) ? 32 : dut.CORDIC_STEPS;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      neg = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      neg = 1;
    end
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= longint'(atan_tab[i]);
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += longint'(atan_tab[i]);
      end
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic [31:0] drive_rate(longint sp, int wheel);
    longint r;
    r = (rad_r != 0) ? rad_r : 1;
    if (!en_r[wheel]) return '0;
    return clamp32(s32(sp) * 65536 / r);
  endfunction

  function automatic pose_t odometry_predict(beat_t b);
    pose_t p;
    longint sep, lin, ang, half, dt, ql, qr, dr, da, c, s;
    longint unsigned hstep;
    sep = (sep_r != 0) ? sep_r : 1;
    p.lv = 0; p.av = 0; p.to = 0;
    if (b.act) begin
      lin = b.lin;
      ang = b.ang;
      half = (ang * sep_r) >>> 17;
      lsp_s = (lin - half) & MASK32;
      rsp_s = (lin + half) & MASK32;
      since_s = 0;
      p.ld = drive_rate(lsp_s, 0);
      p.rd = drive_rate(rsp_s, 1);
      n_cmds++;
    end else begin
      dt = b.dt;
      ql = en_r[0] ? longint'(b.lwr) * rad_r : 0;
      qr = en_r[1] ? longint'(b.rwr) * rad_r : 0;
      dr = (ql + qr) * dt / (64'sd131072 * 64'sd1000000);
      da = (qr - ql) * dt / (sep * 64'sd1000000);
      heading_sin_cos(hd_s, c, s);
      px_s = (px_s + ((dr * c) >>> 30)) & MASK32;
      py_s = (py_s + ((dr * s) >>> 30)) & MASK32;
      hstep = longint'(unsigned'(da)) * 64'd683565276;
      hd_s = (hd_s + longint'(hstep >> 16)) & MASK32;
      if (dt != 0) begin
        p.lv = clamp32((ql + qr) / 131072);
        p.av = clamp32((qr - ql) / sep);
      end
      p.ld = drive_rate(lsp_s, 0);
      p.rd = drive_rate(rsp_s, 1);
      since_s = since_s + dt;
      if (since_s > MASK32) since_s = MASK32;
      if (since_s > tmo_r) begin
        lsp_s = 0;
        rsp_s = 0;
        p.to = 1;
        n_timeouts++;
      end
      n_ticks++;
    end
    p.px = px_s[31:0];
    p.py = py_s[31:0];
    p.hd = hd_s[31:0];
    return p;
  endfunction

  task automatic write_regs(longint sep, longint rad, longint tmo, longint en);
    longint v[4];
    v = '{sep, rad, tmo, en};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= reg_idx_t'(i);
      cfg_data <= v[i][23:0];
      @(negedge clk);
    end
    cfg_we <= 0;
    sep_r = sep & 20'hFFFFF;
    rad_r = rad & 17'h1FFFF;
    tmo_r = tmo & 24'hFFFFFF;
    en_r = en & 3;
  endtask

  task automatic drain();
    while (pose_expect_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send_beat(beat_t b);
    pose_t p;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    action <= b.act;
    left_wheel_rate <= b.lwr;
    right_wheel_rate <= b.rwr;
    step_time_us <= b.dt;
    cmd_linear <= b.lin;
    cmd_angular <= b.ang;
    do @(posedge clk); while (in_stall);
    p = odometry_predict(b);
    // A beat after reset with nothing moving reads back all zeros.
    if (b.zero_known) p = '{px: 0, py: 0, hd: 0, lv: 0, av: 0, ld: 0, rd: 0, to: 0};
    pose_expect_q = {pose_expect_q, p};
    @(negedge clk);
  endtask

  function automatic beat_t rand_beat();
    beat_t b;
    b.act = ($urandom_range(99) < 30);
    b.lwr = 24'($urandom);
    b.rwr = 24'($urandom);
    if ($urandom_range(3) != 0) begin
      b.lwr = $signed(b.lwr) >>> $urandom_range(16);
      b.rwr = $signed(b.rwr) >>> $urandom_range(16);
    end
    case ($urandom_range(5))
      0: b.dt = 20'($urandom);
      1: b.dt = 0;
      default: b.dt = 20'($urandom_range(20000));
    endcase
    b.lin = 24'($urandom);
    b.ang = 24'($urandom);
    if ($urandom_range(1)) begin
      b.lin = $signed(b.lin) >>> $urandom_range(12);
      b.ang = $signed(b.ang) >>> $urandom_range(12);
    end
    b.zero_known = 0;
    return b;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(negedge clk)
    out_stall <= ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    pose_t e;
    if (!rst && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 20000) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pose_expect_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        e = pose_expect_q.pop_front();
        check_field("pos_x", e.px, pos_x);
        check_field("pos_y", e.py, pos_y);
        check_field("heading", e.hd, heading);
        check_field("linear_velocity", e.lv, linear_velocity);
        check_field("angular_velocity", e.av, angular_velocity);
        check_field("left_drive_rate", e.ld, left_drive_rate);
        check_field("right_drive_rate", e.rd, right_drive_rate);
        check_field("timed_out", {31'b0, e.to}, {31'b0, timed_out});
      end
    end
  end

  beat_t directed[$];

  function automatic beat_t mk(bit act, longint l, longint r, longint dt, longint lin,
                               longint ang, bit zk);
    beat_t b;
    b = '{act, l[23:0], r[23:0], dt[19:0], lin[23:0], ang[23:0], zk};
    return b;
  endfunction

  initial begin
    sep_r = SEP_RST; rad_r = RAD_RST; tmo_r = TMO_RST; en_r = EN_RST;
    px_s = 0; py_s = 0; hd_s = 0; lsp_s = 0; rsp_s = 0; since_s = 0;
    repeat (4) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    directed = '{
      mk(0, 0, 0, 0, 0, 0, 1),
      mk(1, 0, 0, 0, 0, 0, 1),
      mk(1, 0, 0, 0, 65536, 32768, 0),
      mk(0, 65536, 65536, 1000000, 0, 0, 0),
      mk(0, -65536, 65536, 500000, 0, 0, 0),
      mk(0, 8388607, 8388607, 1048575, 0, 0, 0),
      mk(0, -8388608, -8388608, 1048575, 0, 0, 0),
      mk(0, -8388608, 8388607, 1000000, 0, 0, 0),
      mk(0, 8388607, -8388608, 0, 0, 0, 0),
      mk(1, 0, 0, 0, 8388607, 8388607, 0),
      mk(1, 0, 0, 0, -8388608, -8388608, 0),
      mk(0, 100000, 30000, 700000, 0, 0, 0),
      mk(0, 100000, 30000, 10, 0, 0, 0),
      mk(1, 0, 0, 0, -8388608, 8388607, 0),
      mk(0, 12345, -54321, 599999, 0, 0, 0),
      mk(0, 12345, -54321, 2, 0, 0, 0)
    };
    foreach (directed[i]) send_beat(directed[i]);
    in_valid <= 0;
    drain();

    // Extremes of every register, zero separation and radius among them.
    write_regs(0, 0, 0, 0);
    directed = '{mk(1, 0, 0, 0, 65536, 65536, 0), mk(0, 65536, 1, 5, 0, 0, 0)};
    foreach (directed[i]) send_beat(directed[i]);
    in_valid <= 0;
    drain();
    write_regs(20'hFFFFF, 17'h1FFFF, 24'hFFFFFF, 1);
    directed = '{mk(1, 0, 0, 0, 8388607, -8388608, 0), mk(0, 8388607, 8388607, 1000000, 0,
                 0, 0), mk(1, 0, 0, 0, -8388608, 8388607, 0)};
    foreach (directed[i]) send_beat(directed[i]);
    in_valid <= 0;
    drain();
    write_regs(1, 1, 10000000, 2);
    directed = '{mk(1, 0, 0, 0, 8388607, 8388607, 0), mk(0, -8388608, 8388607, 1048575, 0,
                 0, 0)};
    foreach (directed[i]) send_beat(directed[i]);
    in_valid <= 0;
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_gap_pct = (ph == 0) ? 22 : (ph == 1) ? 45 : 0;
      recv_stall_pct = (ph == 0) ? 45 : (ph == 1) ? 22 : 0;
      case (ph)
        0: write_regs(655360, 65536, 0, 3);
        1: write_regs($urandom_range(1, 655360), $urandom_range(1, 65536),
                      $urandom_range(0, 50000), $urandom_range(0, 3));
        default: write_regs(SEP_RST, RAD_RST, $urandom_range(1000, 100000), 3);
      endcase
      for (int n = 0; n < 580; n++) begin
        send_beat(rand_beat());
        if (n == 290) begin
          in_valid <= 0;
          drain();
          write_regs($urandom_range(1, 655360), $urandom_range(1, 65536),
                     $urandom_range(0, 200000), $urandom_range(0, 3));
        end
      end
      in_valid <= 0;
      drain();
    end

    $display("Covered %0d ticks and %0d commands under ten register settings,", n_ticks,
             n_cmds);
    $display("with %0d timeouts and three sender/receiver idling mixes.", n_timeouts);
    if (errors == 0 && pose_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
